/* rtl/rsxy_pkg.sv */
package rsxy_pkg;

    localparam int IDX_W        = 3;
    localparam int DIST_W       = 16;
    localparam int COORD_W      = 16;
    localparam int ANG_W        = 17;
    localparam int ORG_W        = 24;
    localparam int XY_W         = 32;
    localparam int Z_W          = 25;
    localparam int ATAN_W       = 22;
    localparam int ATAN_ENTRIES = 24;
    localparam int SUM_W        = 56;
    localparam int PROD_W       = DIST_W + 1 + XY_W;
    localparam int ORG_SHIFT    = 30;
    localparam int ROUND_SHIFT  = 38;

    localparam int FULL_TURN    = 92160;
    localparam int HALF_TURN    = 46080;
    localparam int QUARTER_TURN = 23040;
    localparam int THREE_QUARTER_TURN = 69120;
    localparam int SENSOR_STEP  = 18432;

    localparam logic signed [XY_W-1:0] INV_GAIN = 32'sd652032874;

    localparam logic [ATAN_W-1:0] ATAN_TBL [ATAN_ENTRIES] = '{
        22'd2949120, 22'd1740967, 22'd919879, 22'd466945,
        22'd234379,  22'd117304,  22'd58666,  22'd29335,
        22'd14668,   22'd7334,    22'd3667,   22'd1833,
        22'd917,     22'd458,     22'd229,    22'd115,
        22'd57,      22'd29,      22'd14,     22'd7,
        22'd4,       22'd2,       22'd1,      22'd0
    };

    localparam logic [1:0] REG_ORIGIN_X   = 2'd0;
    localparam logic [1:0] REG_ORIGIN_Y   = 2'd1;
    localparam logic [1:0] REG_BASE_ANGLE = 2'd2;

    typedef struct packed {
        logic                    neg;
        logic [DIST_W-1:0]       distance;
        logic signed [Z_W-1:0]   z;
    } ang_t;

    typedef struct packed {
        logic                    neg;
        logic [DIST_W-1:0]       distance;
        logic signed [XY_W-1:0]  x;
        logic signed [XY_W-1:0]  y;
    } rot_t;

endpackage

/* rtl/range_sensor_polar_to_xy.sv */
// An accepted input beat passes to its output beat through these registers:
// two angle stages, one register per CORDIC rotation and four output stages.
// Throughput is one beat per cycle; every stage holds its item while the next is full.
// Reset clears all valid bits and the origin and base angle registers to zero.
module range_sensor_polar_to_xy
    import rsxy_pkg::*;
#(
    parameter int CORDIC_STAGES = 16
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,  // sensor_index[2:0], distance[18:3], zero pad
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,  // point_x[15:0], point_y[31:16]
    output logic        m_axis_tuser   // clipped
);

    logic signed [ORG_W-1:0]   origin_x_reg;
    logic signed [ORG_W-1:0]   origin_y_reg;
    logic [ANG_W-1:0]          base_angle_reg;
    logic                      cfg_write;
    logic [1:0]                reg_idx;
    logic                      ang_valid;
    logic                      ang_ready;
    ang_t                      ang_data;
    logic                      rot_valid;
    logic                      rot_ready;
    rot_t                      rot_data;
    logic signed [COORD_W-1:0] point_x;
    logic signed [COORD_W-1:0] point_y;

    assign pready    = 1'b1;
    assign reg_idx   = paddr[3:2];
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            origin_x_reg   <= '0;
            origin_y_reg   <= '0;
            base_angle_reg <= '0;
        end
        else if (cfg_write)
        begin
            unique case (reg_idx)
                REG_ORIGIN_X:   origin_x_reg   <= $signed(pwdata[ORG_W-1:0]);
                REG_ORIGIN_Y:   origin_y_reg   <= $signed(pwdata[ORG_W-1:0]);
                REG_BASE_ANGLE: base_angle_reg <= pwdata[ANG_W-1:0];
                default:        ;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_idx)
            REG_ORIGIN_X:   prdata = 32'($signed(origin_x_reg));
            REG_ORIGIN_Y:   prdata = 32'($signed(origin_y_reg));
            REG_BASE_ANGLE: prdata = 32'(base_angle_reg);
            default:        prdata = '0;
        endcase
    end

    rsxy_angle u_angle (
        .clk          (clk),
        .rst_n        (rst_n),
        .base_angle   (base_angle_reg),
        .in_valid     (s_axis_tvalid),
        .in_ready     (s_axis_tready),
        .sensor_index (s_axis_tdata[IDX_W-1:0]),
        .distance     (s_axis_tdata[IDX_W+DIST_W-1:IDX_W]),
        .out_valid    (ang_valid),
        .out_ready    (ang_ready),
        .out_data     (ang_data)
    );

    rsxy_cordic #(
        .STAGES (CORDIC_STAGES)
    ) u_cordic (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (ang_valid),
        .in_ready  (ang_ready),
        .in_data   (ang_data),
        .out_valid (rot_valid),
        .out_ready (rot_ready),
        .out_data  (rot_data)
    );

    rsxy_out u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .origin_x  (origin_x_reg),
        .origin_y  (origin_y_reg),
        .in_valid  (rot_valid),
        .in_ready  (rot_ready),
        .in_data   (rot_data),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .point_x   (point_x),
        .point_y   (point_y),
        .clipped   (m_axis_tuser)
    );

    assign m_axis_tdata = {point_y, point_x};

    // The pipeline only refuses input when every stage is full and the output is stalled.
    assert property (@(posedge clk) disable iff (!rst_n)
        !s_axis_tready |-> (m_axis_tvalid && !m_axis_tready))
        else $error("input stalled while the pipeline has room");

    // A clipped beat carries at least one coordinate at a saturation limit.
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tuser) |->
            (point_x == 16'sh7FFF || point_x == -16'sh8000 ||
             point_y == 16'sh7FFF || point_y == -16'sh8000))
        else $error("clipped flag without a saturated coordinate");

endmodule

/* rtl/rsxy_angle.sv */
module rsxy_angle
    import rsxy_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic [ANG_W-1:0]  base_angle,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [IDX_W-1:0]  sensor_index,
    input  logic [DIST_W-1:0] distance,
    output logic              out_valid,
    input  logic              out_ready,
    output ang_t              out_data
);

    localparam int SUM_A_W = ANG_W + 2;

    logic               va_reg;
    logic [ANG_W-1:0]   ang_reg;
    logic [DIST_W-1:0]  dist_reg;
    logic               vb_reg;
    ang_t               ang_out_reg;
    logic               ready_a;
    logic               ready_b;
    logic [SUM_A_W-1:0] step;
    logic [SUM_A_W-1:0] sum;
    logic [ANG_W-1:0]   ang_next;
    logic signed [ANG_W:0] s;
    ang_t               ang_out_next;

    assign ready_b  = !vb_reg || out_ready;
    assign ready_a  = !va_reg || ready_b;
    assign in_ready = ready_a;

    // The sum stays below three full turns, so at most two turns come off.
    always_comb
    begin
        step = SUM_A_W'(sensor_index) * SUM_A_W'(SENSOR_STEP);
        sum  = SUM_A_W'(base_angle) + step;
        if (sum >= SUM_A_W'(2 * FULL_TURN))
        begin
            ang_next = ANG_W'(sum - SUM_A_W'(2 * FULL_TURN));
        end
        else if (sum >= SUM_A_W'(FULL_TURN))
        begin
            ang_next = ANG_W'(sum - SUM_A_W'(FULL_TURN));
        end
        else
        begin
            ang_next = ANG_W'(sum);
        end
    end

    // Over 1/4 turn, less a half turn and negated; from 3/4 turn, less a full turn.
    always_comb
    begin
        ang_out_next.distance = dist_reg;
        if (ang_reg <= ANG_W'(QUARTER_TURN))
        begin
            s = $signed({1'b0, ang_reg});
            ang_out_next.neg = 1'b0;
        end
        else if (ang_reg < ANG_W'(THREE_QUARTER_TURN))
        begin
            s = $signed({1'b0, ang_reg}) - $signed((ANG_W + 1)'(HALF_TURN));
            ang_out_next.neg = 1'b1;
        end
        else
        begin
            s = $signed({1'b0, ang_reg}) - $signed((ANG_W + 1)'(FULL_TURN));
            ang_out_next.neg = 1'b0;
        end
        ang_out_next.z = $signed({s[Z_W-9:0], 8'b0});
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            va_reg <= 1'b0;
            vb_reg <= 1'b0;
        end
        else
        begin
            if (ready_a)
            begin
                va_reg <= in_valid;
            end
            if (ready_b)
            begin
                vb_reg <= va_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ready_a && in_valid)
        begin
            ang_reg  <= ang_next;
            dist_reg <= distance;
        end
        if (ready_b && va_reg)
        begin
            ang_out_reg <= ang_out_next;
        end
    end

    assign out_valid = vb_reg;
    assign out_data  = ang_out_reg;

endmodule

/* rtl/rsxy_cordic.sv */
module rsxy_cordic
    import rsxy_pkg::*;
#(
    parameter int STAGES = 16
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    output logic in_ready,
    input  ang_t in_data,
    output logic out_valid,
    input  logic out_ready,
    output rot_t out_data
);

    localparam int N = (STAGES < ATAN_ENTRIES) ? STAGES : ATAN_ENTRIES;

    typedef struct packed {
        logic                    neg;
        logic [DIST_W-1:0]       distance;
        logic signed [XY_W-1:0]  x;
        logic signed [XY_W-1:0]  y;
        logic signed [Z_W-1:0]   z;
    } cord_t;

    logic  vld [0:N];
    logic  rdy [0:N];
    cord_t dat [0:N];

    assign vld[0]          = in_valid;
    assign dat[0].neg      = in_data.neg;
    assign dat[0].distance = in_data.distance;
    assign dat[0].x        = INV_GAIN;
    assign dat[0].y        = '0;
    assign dat[0].z        = in_data.z;
    assign rdy[N]          = out_ready;
    assign in_ready        = rdy[0];

    genvar k;
    generate
        for (k = 0; k < N; k++)
        begin : g_stage
            logic                   v_reg;
            cord_t                  d_reg;
            cord_t                  d_next;
            logic signed [XY_W-1:0] dx;
            logic signed [XY_W-1:0] dy;
            logic signed [Z_W-1:0]  da;

            assign dx = $signed(dat[k].y) >>> k;
            assign dy = $signed(dat[k].x) >>> k;
            assign da = $signed(Z_W'(ATAN_TBL[k]));

            always_comb
            begin
                d_next = dat[k];
                if (!dat[k].z[Z_W-1])
                begin
                    d_next.x = dat[k].x - dx;
                    d_next.y = dat[k].y + dy;
                    d_next.z = dat[k].z - da;
                end
                else
                begin
                    d_next.x = dat[k].x + dx;
                    d_next.y = dat[k].y - dy;
                    d_next.z = dat[k].z + da;
                end
            end

            assign rdy[k] = !v_reg || rdy[k+1];

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    v_reg <= 1'b0;
                end
                else if (rdy[k])
                begin
                    v_reg <= vld[k];
                end
            end

            always_ff @(posedge clk)
            begin
                if (rdy[k] && vld[k])
                begin
                    d_reg <= d_next;
                end
            end

            assign vld[k+1] = v_reg;
            assign dat[k+1] = d_reg;
        end
    endgenerate

    assign out_valid         = vld[N];
    assign out_data.neg      = dat[N].neg;
    assign out_data.distance = dat[N].distance;
    assign out_data.x        = dat[N].x;
    assign out_data.y        = dat[N].y;

endmodule

/* rtl/rsxy_out.sv */
module rsxy_out
    import rsxy_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic signed [ORG_W-1:0]   origin_x,
    input  logic signed [ORG_W-1:0]   origin_y,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  rot_t                      in_data,
    output logic                      out_valid,
    input  logic                      out_ready,
    output logic signed [COORD_W-1:0] point_x,
    output logic signed [COORD_W-1:0] point_y,
    output logic                      clipped
);

    localparam int T_W = SUM_W - ROUND_SHIFT + 2;

    logic                      v1_reg;
    logic                      v2_reg;
    logic                      v3_reg;
    logic                      v4_reg;
    logic                      ready1;
    logic                      ready2;
    logic                      ready3;
    logic                      ready4;
    logic signed [XY_W-1:0]    xn_reg;
    logic signed [XY_W-1:0]    yn_reg;
    logic [DIST_W-1:0]         dist_reg;
    logic signed [PROD_W-1:0]  prodx_reg;
    logic signed [PROD_W-1:0]  prody_reg;
    logic signed [PROD_W-1:0]  prodx_next;
    logic signed [PROD_W-1:0]  prody_next;
    logic [SUM_W-1:0]          sumx_reg;
    logic [SUM_W-1:0]          sumy_reg;
    logic [SUM_W-1:0]          sumx_next;
    logic [SUM_W-1:0]          sumy_next;
    logic [COORD_W:0]          resx;
    logic [COORD_W:0]          resy;
    logic signed [COORD_W-1:0] px_reg;
    logic signed [COORD_W-1:0] py_reg;
    logic                      clip_reg;

    function automatic logic [COORD_W:0] round_sat(input logic [SUM_W-1:0] v);
        logic signed [T_W-1:0]   t;
        logic signed [T_W-2:0]   r;
        logic [COORD_W:0]        res;
        t = $signed({v[SUM_W-1], v[SUM_W-1:ROUND_SHIFT-1]}) + $signed(T_W'(1));
        r = $signed(t[T_W-1:1]);
        if (r > $signed((T_W-1)'(32767)))
        begin
            res = {1'b1, 1'b0, {(COORD_W-1){1'b1}}};
        end
        else if (r < -$signed((T_W-1)'(32768)))
        begin
            res = {1'b1, 1'b1, {(COORD_W-1){1'b0}}};
        end
        else
        begin
            res = {1'b0, r[COORD_W-1:0]};
        end
        return res;
    endfunction

    assign ready4   = !v4_reg || out_ready;
    assign ready3   = !v3_reg || ready4;
    assign ready2   = !v2_reg || ready3;
    assign ready1   = !v1_reg || ready2;
    assign in_ready = ready1;

    assign prodx_next = $signed({1'b0, dist_reg}) * yn_reg;
    assign prody_next = $signed({1'b0, dist_reg}) * xn_reg;

    assign sumx_next = {{(SUM_W-PROD_W){prodx_reg[PROD_W-1]}}, prodx_reg}
                     + {{(SUM_W-ORG_W-ORG_SHIFT){origin_x[ORG_W-1]}}, origin_x,
                        {ORG_SHIFT{1'b0}}};
    assign sumy_next = {{(SUM_W-PROD_W){prody_reg[PROD_W-1]}}, prody_reg}
                     + {{(SUM_W-ORG_W-ORG_SHIFT){origin_y[ORG_W-1]}}, origin_y,
                        {ORG_SHIFT{1'b0}}};

    assign resx = round_sat(sumx_reg);
    assign resy = round_sat(sumy_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else
        begin
            if (ready1)
            begin
                v1_reg <= in_valid;
            end
            if (ready2)
            begin
                v2_reg <= v1_reg;
            end
            if (ready3)
            begin
                v3_reg <= v2_reg;
            end
            if (ready4)
            begin
                v4_reg <= v3_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ready1 && in_valid)
        begin
            xn_reg   <= in_data.neg ? -in_data.x : in_data.x;
            yn_reg   <= in_data.neg ? -in_data.y : in_data.y;
            dist_reg <= in_data.distance;
        end
        if (ready2 && v1_reg)
        begin
            prodx_reg <= prodx_next;
            prody_reg <= prody_next;
        end
        if (ready3 && v2_reg)
        begin
            sumx_reg <= sumx_next;
            sumy_reg <= sumy_next;
        end
        if (ready4 && v3_reg)
        begin
            px_reg   <= $signed(resx[COORD_W-1:0]);
            py_reg   <= $signed(resy[COORD_W-1:0]);
            clip_reg <= resx[COORD_W] | resy[COORD_W];
        end
    end

    assign out_valid = v4_reg;
    assign point_x   = px_reg;
    assign point_y   = py_reg;
    assign clipped   = clip_reg;

endmodule
